// ===== rtl/core/arpc_pkg.sv =====
// ----------------------------------------------------------------------------
// arpc_pkg
// Shared types and constants for the ARP responder with address cache.
// ----------------------------------------------------------------------------
package arpc_pkg;

  localparam int IP_W  = 32;
  localparam int MAC_W = 48;
  localparam int CFG_W = 48;

  localparam logic [15:0] HW_ETHERNET   = 16'h0001;
  localparam logic [15:0] PROTO_IPV4    = 16'h0800;
  localparam logic [15:0] KIND_REQUEST  = 16'h0001;
  localparam logic [15:0] KIND_RESPONSE = 16'h0002;

  typedef enum logic [1:0] {
    ACT_NONE    = 2'd0,
    ACT_REPLY   = 2'd1,
    ACT_HIT     = 2'd2,
    ACT_REQUEST = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    CMD_NONE  = 2'd0,
    CMD_REPLY = 2'd1,
    CMD_LEARN = 2'd2,
    CMD_QUERY = 2'd3
  } cmd_kind_t;

  typedef enum logic {
    OP_MESSAGE = 1'b0,
    OP_QUERY   = 1'b1
  } opcode_t;

  typedef enum logic {
    CFG_OWN_IP  = 1'b0,
    CFG_OWN_MAC = 1'b1
  } cfg_addr_t;

  // classified work item handed from front to back
  typedef struct packed {
    cmd_kind_t          kind;
    logic [IP_W-1:0]    ip;
    logic [MAC_W-1:0]   mac;
  } cmd_t;

  typedef struct packed {
    action_t            action;
    logic [MAC_W-1:0]   mac;
    logic [IP_W-1:0]    ip;
  } result_t;

endpackage

// ===== rtl/core/arpc_front.sv =====
// ----------------------------------------------------------------------------
// arpc_front
// Holds the node address, filters and classifies incoming transactions and
// queues the resulting commands for the back end (two-entry queue).
// ----------------------------------------------------------------------------
module arpc_front (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [0:0]               cfg_addr,
  input  logic [arpc_pkg::CFG_W-1:0] cfg_wdata,
  input  logic                     push,
  output logic                     full,
  input  logic                     in_opcode,
  input  logic                     in_length_ok,
  input  logic [15:0]              in_hardware_type,
  input  logic [15:0]              in_protocol_type,
  input  logic [15:0]              in_message_kind,
  input  logic [47:0]              in_sender_mac,
  input  logic [31:0]              in_sender_ip,
  input  logic [31:0]              in_target_ip,
  input  logic [31:0]              in_query_ip,
  output logic                     cmd_vld,
  output arpc_pkg::cmd_t           cmd,
  input  logic                     cmd_rdy
);
  import arpc_pkg::*;

  logic [IP_W-1:0] own_ip_r;
  cmd_t            cls;
  logic            msg_ok;
  cmd_t            q_r [2];
  logic            wr_ptr_r, rd_ptr_r;
  logic [1:0]      cnt_r;
  logic            do_push, do_pop;

  // own_mac is not stored here; writes to it are taken and dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_ip_r <= '0;
    end else if (cfg_we) begin
      case (cfg_addr_t'(cfg_addr))
        CFG_OWN_IP:  own_ip_r <= cfg_wdata[IP_W-1:0];
        CFG_OWN_MAC: ;
        default: ;
      endcase
    end
  end

  assign msg_ok = in_length_ok && (in_hardware_type == HW_ETHERNET) &&
                  (in_protocol_type == PROTO_IPV4) && (in_target_ip == own_ip_r);

  always_comb begin
    cls = '{kind: CMD_NONE, ip: '0, mac: '0};
    if (opcode_t'(in_opcode) == OP_QUERY) begin
      cls.kind = CMD_QUERY;
      cls.ip   = in_query_ip;
    end else if (msg_ok && in_message_kind == KIND_REQUEST) begin
      cls = '{kind: CMD_REPLY, ip: in_sender_ip, mac: in_sender_mac};
    end else if (msg_ok && in_message_kind == KIND_RESPONSE) begin
      cls = '{kind: CMD_LEARN, ip: in_sender_ip, mac: in_sender_mac};
    end
  end

  assign full    = (cnt_r == 2'd2);
  assign cmd_vld = (cnt_r != 2'd0);
  assign cmd     = q_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = cmd_vld && cmd_rdy;

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_ptr_r] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (do_push) wr_ptr_r <= ~wr_ptr_r;
      if (do_pop)  rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_r + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

// ===== rtl/core/arpc_back.sv =====
// ----------------------------------------------------------------------------
// arpc_back
// Executes queued commands: sequential cache scan, round-robin cache fill
// and the result register toward the output queue interface.
// ----------------------------------------------------------------------------
module arpc_back #(
  parameter int CACHE_ENTRIES = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cmd_vld,
  input  arpc_pkg::cmd_t     cmd,
  output logic               cmd_rdy,
  output logic               empty,
  input  logic               pop,
  output arpc_pkg::result_t  res
);
  import arpc_pkg::*;

  localparam int IDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
  localparam logic [IDX_W-1:0] LAST = IDX_W'(CACHE_ENTRIES - 1);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_UPDATE = 4'b0100,
    ST_RESULT = 4'b1000
  } state_t;

  state_t                   state_r, state_nxt;
  cmd_t                     cmd_r, cmd_nxt;
  logic [IDX_W-1:0]         scan_idx_r, scan_idx_nxt;
  logic                     issue_done_r, issue_done_nxt;
  logic                     rd_vld_r, rd_vld_nxt;
  logic [IDX_W-1:0]         rd_idx_r, rd_idx_nxt;
  logic                     rd_ent_vld_r;
  logic [IP_W-1:0]          rd_ip_r;
  logic [MAC_W-1:0]         rd_mac_r;
  logic [CACHE_ENTRIES-1:0] valid_r, valid_nxt;
  logic [IDX_W-1:0]         wr_ptr_r, wr_ptr_nxt;
  result_t                  pend_r, pend_nxt;
  result_t                  res_r, res_nxt;
  logic                     res_vld_r, res_vld_nxt;
  logic                     mem_we;
  logic [IP_W-1:0]          ent_ip;
  logic [MAC_W-1:0]         ent_mac;

  logic [IP_W-1:0]  ip_mem  [CACHE_ENTRIES];
  logic [MAC_W-1:0] mac_mem [CACHE_ENTRIES];

  // cache storage, registered read at the scan index
  always_ff @(posedge clk) begin
    if (mem_we) begin
      ip_mem[wr_ptr_r]  <= cmd_r.ip;
      mac_mem[wr_ptr_r] <= cmd_r.mac;
    end
    rd_ip_r  <= ip_mem[scan_idx_r];
    rd_mac_r <= mac_mem[scan_idx_r];
  end

  // entries never written read as zero
  assign ent_ip  = rd_ent_vld_r ? rd_ip_r  : '0;
  assign ent_mac = rd_ent_vld_r ? rd_mac_r : '0;

  assign cmd_rdy = (state_r == ST_IDLE);
  assign empty   = !res_vld_r;
  assign res     = res_r;

  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    scan_idx_nxt   = scan_idx_r;
    issue_done_nxt = issue_done_r;
    rd_vld_nxt     = rd_vld_r;
    rd_idx_nxt     = rd_idx_r;
    valid_nxt      = valid_r;
    wr_ptr_nxt     = wr_ptr_r;
    pend_nxt       = pend_r;
    res_nxt        = res_r;
    res_vld_nxt    = res_vld_r && !pop;
    mem_we         = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (cmd_vld) begin
          cmd_nxt = cmd;
          case (cmd.kind)
            CMD_QUERY, CMD_LEARN: begin
              scan_idx_nxt   = '0;
              issue_done_nxt = 1'b0;
              rd_vld_nxt     = 1'b0;
              state_nxt      = ST_SCAN;
            end
            CMD_REPLY: begin
              pend_nxt  = '{action: ACT_REPLY, mac: cmd.mac, ip: cmd.ip};
              state_nxt = ST_RESULT;
            end
            default: begin
              pend_nxt  = '{action: ACT_NONE, mac: '0, ip: '0};
              state_nxt = ST_RESULT;
            end
          endcase
        end
      end

      ST_SCAN: begin
        // issue stage: one read per cycle
        if (!issue_done_r) begin
          rd_vld_nxt = 1'b1;
          rd_idx_nxt = scan_idx_r;
          if (scan_idx_r == LAST) begin
            issue_done_nxt = 1'b1;
          end else begin
            scan_idx_nxt = scan_idx_r + 1'b1;
          end
        end else begin
          rd_vld_nxt = 1'b0;
        end
        // compare stage: lowest matching entry wins
        if (rd_vld_r) begin
          if (ent_ip == cmd_r.ip) begin
            rd_vld_nxt = 1'b0;
            state_nxt  = ST_RESULT;
            if (cmd_r.kind == CMD_QUERY) begin
              pend_nxt = '{action: ACT_HIT, mac: ent_mac, ip: '0};
            end else begin
              pend_nxt = '{action: ACT_NONE, mac: '0, ip: '0};
            end
          end else if (rd_idx_r == LAST) begin
            rd_vld_nxt = 1'b0;
            if (cmd_r.kind == CMD_QUERY) begin
              pend_nxt  = '{action: ACT_REQUEST, mac: '0, ip: cmd_r.ip};
              state_nxt = ST_RESULT;
            end else begin
              pend_nxt  = '{action: ACT_NONE, mac: '0, ip: '0};
              state_nxt = ST_UPDATE;
            end
          end
        end
      end

      ST_UPDATE: begin
        mem_we              = 1'b1;
        valid_nxt[wr_ptr_r] = 1'b1;
        wr_ptr_nxt          = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
        state_nxt           = ST_RESULT;
      end

      ST_RESULT: begin
        if (!res_vld_r || pop) begin
          res_nxt     = pend_r;
          res_vld_nxt = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      issue_done_r <= 1'b0;
      rd_vld_r     <= 1'b0;
      valid_r      <= '0;
      wr_ptr_r     <= '0;
      res_vld_r    <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      issue_done_r <= issue_done_nxt;
      rd_vld_r     <= rd_vld_nxt;
      valid_r      <= valid_nxt;
      wr_ptr_r     <= wr_ptr_nxt;
      res_vld_r    <= res_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    scan_idx_r   <= scan_idx_nxt;
    rd_idx_r     <= rd_idx_nxt;
    rd_ent_vld_r <= valid_r[scan_idx_r];
    pend_r       <= pend_nxt;
    res_r        <= res_nxt;
  end

endmodule

// ===== rtl/core/arp_responder_with_cache_top.sv =====
// ----------------------------------------------------------------------------
// arp_responder_with_cache_top
// ARP responder and resolver with a small round-robin address cache.
// ----------------------------------------------------------------------------
// Each accepted transaction yields exactly one result, in order. The front end
// filters and classifies a transaction in the cycle it is pushed and parks it
// in a two-entry command queue, so push keeps being taken, until two commands
// wait there, while the back end works or a result waits to be popped. Replies
// and dropped messages go from idle straight to the result state in the back
// end. Queries and accepted ARP responses scan the cache one entry per cycle
// through its single registered read port, and a response that misses writes
// the cache in an update state after the scan. Cache contents read as zero
// until written, so after reset IP 0 matches entry 0.
module arp_responder_with_cache_top #(
  parameter int CACHE_ENTRIES = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_addr,
  input  logic [47:0] cfg_wdata,
  input  logic        push,
  output logic        full,
  input  logic        in_opcode,
  input  logic        in_length_ok,
  input  logic [15:0] in_hardware_type,
  input  logic [15:0] in_protocol_type,
  input  logic [15:0] in_message_kind,
  input  logic [47:0] in_sender_mac,
  input  logic [31:0] in_sender_ip,
  input  logic [31:0] in_target_ip,
  input  logic [31:0] in_query_ip,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  out_action,
  output logic [47:0] out_mac,
  output logic [31:0] out_ip
);
  import arpc_pkg::*;

  logic    cmd_vld, cmd_rdy;
  cmd_t    cmd;
  result_t res;

  arpc_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_addr         (cfg_addr),
    .cfg_wdata        (cfg_wdata),
    .push             (push),
    .full             (full),
    .in_opcode        (in_opcode),
    .in_length_ok     (in_length_ok),
    .in_hardware_type (in_hardware_type),
    .in_protocol_type (in_protocol_type),
    .in_message_kind  (in_message_kind),
    .in_sender_mac    (in_sender_mac),
    .in_sender_ip     (in_sender_ip),
    .in_target_ip     (in_target_ip),
    .in_query_ip      (in_query_ip),
    .cmd_vld          (cmd_vld),
    .cmd              (cmd),
    .cmd_rdy          (cmd_rdy)
  );

  arpc_back #(
    .CACHE_ENTRIES (CACHE_ENTRIES)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd_vld (cmd_vld),
    .cmd     (cmd),
    .cmd_rdy (cmd_rdy),
    .empty   (empty),
    .pop     (pop),
    .res     (res)
  );

  assign out_action = res.action;
  assign out_mac    = res.mac;
  assign out_ip     = res.ip;

endmodule

// ===== rtl/core/arpc_checker.sv =====
// ----------------------------------------------------------------------------
// arpc_checker
// Port-level checks for the ARP responder, bound to the top level.
// ----------------------------------------------------------------------------
module arpc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        push,
  input logic        full,
  input logic        empty,
  input logic        pop,
  input logic [1:0]  out_action,
  input logic [47:0] out_mac,
  input logic [31:0] out_ip
);
  import arpc_pkg::*;

  // reset leaves both queues drained
  a_reset_drains: assert property (@(posedge clk)
    !rst_n |=> (!full && empty))
    else $error("queues not drained after reset");

  // a waiting result holds until popped
  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_action) && $stable(out_mac) &&
                          $stable(out_ip)))
    else $error("pending result changed while stalled");

  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_action == ACT_NONE) |-> (out_mac == '0 && out_ip == '0))
    else $error("no-action result carries address data");

  a_hit_no_ip: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_action == ACT_HIT) |-> (out_ip == '0))
    else $error("cache hit carries an IP");

  a_request_no_mac: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_action == ACT_REQUEST) |-> (out_mac == '0))
    else $error("broadcast request carries a MAC");

endmodule

bind arp_responder_with_cache_top arpc_checker u_arpc_checker (.*);

// ===== sim/tb_arp_responder_with_cache_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_arp_responder_with_cache_top
// Self-checking bench for the ARP responder with round-robin address cache.
// Drives ARP messages and resolve queries through the push/full side, pops
// results under random backpressure and checks each one against a local
// predictor that keeps its own copy of the address cache and node registers.
// ----------------------------------------------------------------------------
module tb_arp_responder_with_cache_top;
  import arpc_pkg::*;

  localparam int CACHE_ENTRIES = 8;
  localparam int PHASE_ITEMS   = 185;
  localparam int POOL_SIZE     = 12;
  localparam int STALL_LIMIT   = 4000;
  localparam int SETTLE_CYCLES = CACHE_ENTRIES + 8;

  typedef struct {
    opcode_t     opcode;
    bit          length_ok;
    bit [15:0]   hw_type;
    bit [15:0]   ptype;
    bit [15:0]   kind;
    bit [47:0]   sender_mac;
    bit [31:0]   sender_ip;
    bit [31:0]   target_ip;
    bit [31:0]   query_ip;
  } arp_txn_t;

  // Predicts one result per transaction from a private copy of the cache.
  class arp_scoreboard;
    bit [31:0] own_ip;
    bit [47:0] own_mac;
    bit [31:0] cache_ip  [CACHE_ENTRIES];
    bit [47:0] cache_mac [CACHE_ENTRIES];
    int        wr_ptr;
    result_t   expected_q[$];
    int        mismatches;

    function new();
      own_ip     = '0;
      own_mac    = '0;
      wr_ptr     = 0;
      mismatches = 0;
      foreach (cache_ip[i]) begin
        cache_ip[i]  = '0;
        cache_mac[i] = '0;
      end
    endfunction

    function void set_reg(cfg_addr_t addr, bit [47:0] value);
      if (addr == CFG_OWN_IP) own_ip = value[31:0];
      else own_mac = value;
    endfunction

    function int find_entry(bit [31:0] ip);
      for (int i = 0; i < CACHE_ENTRIES; i++) begin
        if (cache_ip[i] == ip) return i;
      end
      return -1;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void note_txn(arp_txn_t t);
      result_t r;
      int      k;
      r.action = ACT_NONE;
      r.mac    = '0;
      r.ip     = '0;
      if (t.opcode == OP_QUERY) begin
        k = find_entry(t.query_ip);
        if (k >= 0) begin
          r.action = ACT_HIT;
          r.mac    = cache_mac[k];
        end else begin
          r.action = ACT_REQUEST;
          r.ip     = t.query_ip;
        end
      end else if (t.length_ok && t.hw_type == HW_ETHERNET &&
                   t.ptype == PROTO_IPV4 && t.target_ip == own_ip) begin
        if (t.kind == KIND_REQUEST) begin
          r.action = ACT_REPLY;
          r.mac    = t.sender_mac;
          r.ip     = t.sender_ip;
        end else if (t.kind == KIND_RESPONSE && find_entry(t.sender_ip) < 0) begin
          cache_ip[wr_ptr]  = t.sender_ip;
          cache_mac[wr_ptr] = t.sender_mac;
          wr_ptr = (wr_ptr + 1) % CACHE_ENTRIES;
        end
      end
      expected_q.push_back(r);
    endfunction

    function void report(string msg);
      mismatches++;
      if (mismatches <= 10) $display("[%0t] %s", $time, msg);
    endfunction

    function void check_result(logic [1:0] act, logic [47:0] mac, logic [31:0] ip);
      result_t r;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result action=%0d mac=%h ip=%h", act, mac, ip));
        return;
      end
      r = expected_q.pop_front();
      if (r.action !== act || r.mac !== mac || r.ip !== ip)
        report($sformatf({"result mismatch: exp action=%0d mac=%h ip=%h, ",
                          "got action=%0d mac=%h ip=%h"},
                         r.action, r.mac, r.ip, act, mac, ip));
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [0:0]  cfg_addr;
  logic [47:0] cfg_wdata;
  logic        push;
  logic        full;
  logic        in_opcode;
  logic        in_length_ok;
  logic [15:0] in_hardware_type;
  logic [15:0] in_protocol_type;
  logic [15:0] in_message_kind;
  logic [47:0] in_sender_mac;
  logic [31:0] in_sender_ip;
  logic [31:0] in_target_ip;
  logic [31:0] in_query_ip;
  logic        empty;
  logic        pop;
  logic [1:0]  out_action;
  logic [47:0] out_mac;
  logic [31:0] out_ip;

  arp_scoreboard sb = new();
  bit            idle_on;
  bit [31:0]     ip_pool [POOL_SIZE];
  int            stall_cnt = 0;

  arp_responder_with_cache_top #(
    .CACHE_ENTRIES(CACHE_ENTRIES)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_addr         (cfg_addr),
    .cfg_wdata        (cfg_wdata),
    .push             (push),
    .full             (full),
    .in_opcode        (in_opcode),
    .in_length_ok     (in_length_ok),
    .in_hardware_type (in_hardware_type),
    .in_protocol_type (in_protocol_type),
    .in_message_kind  (in_message_kind),
    .in_sender_mac    (in_sender_mac),
    .in_sender_ip     (in_sender_ip),
    .in_target_ip     (in_target_ip),
    .in_query_ip      (in_query_ip),
    .empty            (empty),
    .pop              (pop),
    .out_action       (out_action),
    .out_mac          (out_mac),
    .out_ip           (out_ip)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  function automatic bit [47:0] rand48();
    return {16'($urandom), 32'($urandom)};
  endfunction

  // Well-formed message aimed at this node.
  function automatic arp_txn_t arp_msg(bit [15:0] kind, bit [31:0] sip, bit [47:0] smac);
    arp_txn_t t;
    t.opcode     = OP_MESSAGE;
    t.length_ok  = 1'b1;
    t.hw_type    = HW_ETHERNET;
    t.ptype      = PROTO_IPV4;
    t.kind       = kind;
    t.sender_mac = smac;
    t.sender_ip  = sip;
    t.target_ip  = sb.own_ip;
    t.query_ip   = '0;
    return t;
  endfunction

  function automatic arp_txn_t resolve(bit [31:0] ip);
    arp_txn_t t;
    t = arp_msg(16'h0, '0, '0);
    t.opcode    = OP_QUERY;
    t.target_ip = '0;
    t.query_ip  = ip;
    return t;
  endfunction

  function automatic bit [31:0] pick_ip();
    if ($urandom_range(0, 99) < 75) return ip_pool[$urandom_range(0, POOL_SIZE - 1)];
    return $urandom;
  endfunction

  function automatic arp_txn_t random_txn();
    arp_txn_t t;
    int       r;
    bit [15:0] kind;
    r = $urandom_range(0, 99);
    if (r < 35) begin
      // query with junk in every field it ignores
      t.opcode     = OP_QUERY;
      t.length_ok  = 1'($urandom);
      t.hw_type    = 16'($urandom);
      t.ptype      = 16'($urandom);
      t.kind       = 16'($urandom);
      t.sender_mac = rand48();
      t.sender_ip  = $urandom;
      t.target_ip  = $urandom;
      t.query_ip   = pick_ip();
    end else begin
      r = $urandom_range(0, 99);
      if (r < 45) kind = KIND_REQUEST;
      else if (r < 90) kind = KIND_RESPONSE;
      else kind = 16'($urandom);
      t = arp_msg(kind, pick_ip(), rand48());
      t.query_ip = $urandom;
      if ($urandom_range(0, 99) < 25) begin
        case ($urandom_range(0, 4))
          0: t.length_ok = 1'b0;
          1: t.hw_type = 16'($urandom);
          2: t.ptype = 16'($urandom);
          3: t.target_ip = $urandom;
          default: begin
            t.length_ok  = 1'($urandom);
            t.hw_type    = 16'($urandom);
            t.ptype      = 16'($urandom);
            t.kind       = 16'($urandom);
            t.target_ip  = $urandom;
          end
        endcase
      end
    end
    return t;
  endfunction

  // Called at a falling edge; returns at a falling edge.
  task automatic send_txn(arp_txn_t t);
    while (idle_on && $urandom_range(0, 99) < 20) begin
      push = 1'b0;
      @(negedge clk);
    end
    in_opcode        = t.opcode;
    in_length_ok     = t.length_ok;
    in_hardware_type = t.hw_type;
    in_protocol_type = t.ptype;
    in_message_kind  = t.kind;
    in_sender_mac    = t.sender_mac;
    in_sender_ip     = t.sender_ip;
    in_target_ip     = t.target_ip;
    in_query_ip      = t.query_ip;
    push             = 1'b1;
    do @(posedge clk); while (full);
    sb.note_txn(t);
    @(negedge clk);
  endtask

  // Let every outstanding result drain, plus time for a trailing cache write.
  task automatic wait_drained();
    push = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(cfg_addr_t addr, bit [47:0] value);
    cfg_we    = 1'b1;
    cfg_addr  = addr;
    cfg_wdata = value;
    sb.set_reg(addr, value);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // result side
  initial begin
    pop = 1'b0;
    forever begin
      @(negedge clk);
      pop = !(idle_on && $urandom_range(0, 99) < 20);
      @(posedge clk);
      if (rst_n && pop && !empty) sb.check_result(out_action, out_mac, out_ip);
    end
  end

  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty)) stall_cnt <= 0;
    else stall_cnt <= stall_cnt + 1;
    if (stall_cnt >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    arp_txn_t t;
    bit [31:0] ip_a;
    idle_on          = 1'b1;
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_addr         = '0;
    cfg_wdata        = '0;
    push             = 1'b0;
    in_opcode        = 1'b0;
    in_length_ok     = 1'b0;
    in_hardware_type = '0;
    in_protocol_type = '0;
    in_message_kind  = '0;
    in_sender_mac    = '0;
    in_sender_ip     = '0;
    in_target_ip     = '0;
    in_query_ip      = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // registers still at reset: IP 0 is ours and matches the unwritten cache
    send_txn(resolve(32'h0));
    send_txn(resolve(32'hFFFF_FFFF));
    send_txn(arp_msg(KIND_RESPONSE, 32'h0, 48'hFFFF_FFFF_FFFF));
    send_txn(resolve(32'h0));

    wait_drained();
    write_reg(CFG_OWN_IP, 48'h0000_FFFF_FFFF);
    write_reg(CFG_OWN_MAC, 48'hFFFF_FFFF_FFFF);

    send_txn(arp_msg(KIND_REQUEST, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF));
    send_txn(arp_msg(KIND_REQUEST, 32'h0, 48'h0));
    t = arp_msg(KIND_REQUEST, 32'h0102_0304, 48'h0A0B_0C0D_0E0F);
    t.length_ok = 1'b0;       send_txn(t);
    t.length_ok = 1'b1;
    t.hw_type = 16'hFFFF;     send_txn(t);
    t.hw_type = 16'h0000;     send_txn(t);
    t.hw_type = HW_ETHERNET;
    t.ptype = 16'hFFFF;       send_txn(t);
    t.ptype = 16'h0806;       send_txn(t);
    t.ptype = PROTO_IPV4;
    t.target_ip = 32'h0;      send_txn(t);
    t.target_ip = sb.own_ip;
    t.kind = 16'h0000;        send_txn(t);
    t.kind = 16'h0003;        send_txn(t);
    t.kind = 16'hFFFF;        send_txn(t);

    // learn, hit, no refresh on a repeated response, lowest unwritten entry
    ip_a = 32'h0A00_0001;
    send_txn(arp_msg(KIND_RESPONSE, ip_a, 48'h1122_3344_5566));
    send_txn(resolve(ip_a));
    send_txn(arp_msg(KIND_RESPONSE, ip_a, 48'h6655_4433_2211));
    send_txn(resolve(ip_a));
    send_txn(resolve(32'h0));
    t = resolve(32'hFFFF_FFFF);
    t.length_ok  = 1'b1;
    t.hw_type    = 16'hFFFF;
    t.ptype      = 16'hFFFF;
    t.kind       = 16'hFFFF;
    t.sender_mac = 48'hFFFF_FFFF_FFFF;
    t.sender_ip  = 32'hFFFF_FFFF;
    t.target_ip  = 32'hFFFF_FFFF;
    send_txn(t);
    send_txn(arp_msg(KIND_RESPONSE, 32'hFFFF_FFFF, 48'h8000_0000_0001));
    send_txn(resolve(32'hFFFF_FFFF));

    for (int p = 0; p < 5; p++) begin
      wait_drained();
      case (p)
        0: begin
          write_reg(CFG_OWN_IP, {16'h0, 32'($urandom)});
          write_reg(CFG_OWN_MAC, rand48());
        end
        1: begin
          write_reg(CFG_OWN_IP, 48'h0);
          write_reg(CFG_OWN_MAC, 48'h0);
        end
        2: begin
          write_reg(CFG_OWN_IP, 48'h0000_FFFF_FFFF);
          write_reg(CFG_OWN_MAC, 48'hFFFF_FFFF_FFFF);
        end
        3: begin
          write_reg(CFG_OWN_IP, {16'h0, 32'($urandom)});
          write_reg(CFG_OWN_MAC, 48'h0);
        end
        default: begin
          write_reg(CFG_OWN_IP, {16'h0, 32'($urandom)});
          write_reg(CFG_OWN_MAC, rand48());
        end
      endcase
      idle_on = (p != 1);
      ip_pool[0] = 32'h0;
      ip_pool[1] = 32'hFFFF_FFFF;
      for (int i = 2; i < POOL_SIZE; i++) ip_pool[i] = $urandom;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 3 && n == PHASE_ITEMS / 2) wait_drained();
        send_txn(random_txn());
      end
    end

    wait_drained();
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/arpc_pkg.sv
rtl/core/arpc_front.sv
rtl/core/arpc_back.sv
rtl/core/arp_responder_with_cache_top.sv
rtl/core/arpc_checker.sv
sim/tb_arp_responder_with_cache_top.sv
